// ----- rtl/mqts_pkg.sv -----
// Shared types and constants for the two-stack minimum queue.
package mqts_pkg;

  localparam int unsigned DEPTH = 1024;
  localparam int unsigned AW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH + 1);
  localparam int unsigned DW    = 32;

  localparam logic MODE_PUSH = 1'b0;
  localparam logic MODE_POP  = 1'b1;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_POP_EMPTY = 2'd1,
    ST_PUSH_FULL = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_XFER,
    S_POP,
    S_POP_WAIT,
    S_RESP
  } ctl_state_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic    push;
    logic    set_status;
    status_t status_code;
    logic    xfer_rd;
    logic    xfer_wr;
    logic    pop_out;
    logic    pop_load;
  } dp_cmd_t;

  // Status from the datapath back to the controller.
  typedef struct packed {
    logic full;
    logic empty;
    logic in_empty;
    logic out_empty;
  } dp_sts_t;

endpackage

// ----- rtl/mqts_dp.sv -----
// Datapath: stack memories, stack counts, top minima and result fields.
module mqts_dp
  import mqts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  dp_cmd_t              cmd,
  input  logic signed [DW-1:0] value,
  output dp_sts_t              sts,
  output logic signed [DW-1:0] min_value,
  output logic [CW-1:0]        count,
  output logic                 is_empty,
  output status_t              status
);

  // Input stack keeps values only; its minimum below the top is never needed
  // because the stack is only ever emptied whole.
  logic signed [DW-1:0] in_vals  [DEPTH];
  // Output stack keeps running minima only; popped values are not reported.
  logic signed [DW-1:0] out_mins [DEPTH];

  logic [CW-1:0]        in_cnt;
  logic [CW-1:0]        out_cnt;
  logic signed [DW-1:0] in_top_min;
  logic signed [DW-1:0] out_top_min;
  logic signed [DW-1:0] in_rd_data;
  logic signed [DW-1:0] out_rd_data;

  logic signed [DW-1:0] push_min;
  logic signed [DW-1:0] xfer_min;
  logic [CW-1:0]        total;
  logic [CW-1:0]        in_last;
  logic [CW-1:0]        out_below;

  assign push_min = (in_cnt == '0) ? value :
                    ((value < in_top_min) ? value : in_top_min);
  assign xfer_min = (out_cnt == '0) ? in_rd_data :
                    ((in_rd_data < out_top_min) ? in_rd_data : out_top_min);
  assign total     = in_cnt + out_cnt;
  assign in_last   = in_cnt - CW'(1);
  assign out_below = out_cnt - CW'(2);

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_vals[in_cnt[AW-1:0]] <= value;
    end
    if (cmd.xfer_rd) begin
      in_rd_data <= in_vals[in_last[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.xfer_wr) begin
      out_mins[out_cnt[AW-1:0]] <= xfer_min;
    end
    if (cmd.pop_out) begin
      out_rd_data <= out_mins[out_below[AW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      in_cnt  <= '0;
      out_cnt <= '0;
      status  <= ST_OK;
    end else begin
      if (cmd.push) begin
        in_cnt <= in_cnt + CW'(1);
      end else if (cmd.xfer_rd) begin
        in_cnt <= in_last;
      end
      if (cmd.xfer_wr) begin
        out_cnt <= out_cnt + CW'(1);
      end else if (cmd.pop_out) begin
        out_cnt <= out_cnt - CW'(1);
      end
      if (cmd.set_status) begin
        status <= cmd.status_code;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.push) begin
      in_top_min <= push_min;
    end
    if (cmd.xfer_wr) begin
      out_top_min <= xfer_min;
    end else if (cmd.pop_load && out_cnt != '0) begin
      out_top_min <= out_rd_data;
    end
  end

  always_comb begin
    priority if (in_cnt != '0 && out_cnt != '0) begin
      min_value = (in_top_min < out_top_min) ? in_top_min : out_top_min;
    end else if (in_cnt != '0) begin
      min_value = in_top_min;
    end else if (out_cnt != '0) begin
      min_value = out_top_min;
    end else begin
      min_value = '0;
    end
  end

  assign count         = total;
  assign is_empty      = (total == '0);
  assign sts.full      = (total >= CW'(DEPTH));
  assign sts.empty     = (total == '0);
  assign sts.in_empty  = (in_cnt == '0);
  assign sts.out_empty = (out_cnt == '0);

endmodule

// ----- rtl/mqts_ctrl.sv -----
// Controller: sequences push, transfer and pop for each request.
module mqts_ctrl
  import mqts_pkg::*;
(
  input  logic    clk,
  input  logic    rst,
  input  logic    start,
  input  logic    mode,
  input  dp_sts_t sts,
  output dp_cmd_t cmd,
  output logic    busy,
  output logic    done
);

  ctl_state_t state;
  ctl_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    done       = 1'b0;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.set_status = 1'b1;
          if (mode == MODE_PUSH) begin
            if (sts.full) begin
              cmd.status_code = ST_PUSH_FULL;
            end else begin
              cmd.status_code = ST_OK;
              cmd.push        = 1'b1;
            end
            state_next = S_RESP;
          end else if (sts.empty) begin
            cmd.status_code = ST_POP_EMPTY;
            state_next      = S_RESP;
          end else if (sts.out_empty) begin
            cmd.status_code = ST_OK;
            cmd.xfer_rd     = 1'b1;
            state_next      = S_XFER;
          end else begin
            cmd.status_code = ST_OK;
            cmd.pop_out     = 1'b1;
            state_next      = S_POP_WAIT;
          end
        end
      end
      S_XFER: begin
        // write the element read last cycle, fetch the next while any remain
        cmd.xfer_wr = 1'b1;
        if (!sts.in_empty) begin
          cmd.xfer_rd = 1'b1;
        end else begin
          state_next = S_POP;
        end
      end
      S_POP: begin
        cmd.pop_out = 1'b1;
        state_next  = S_POP_WAIT;
      end
      S_POP_WAIT: begin
        cmd.pop_load = 1'b1;
        state_next   = S_RESP;
      end
      S_RESP: begin
        done       = 1'b1;
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  assign busy = (state != S_IDLE);

endmodule

// ----- rtl/min_queue_two_stacks_core.sv -----
// Top level of the two-stack minimum queue.
//
// A FIFO of signed 32-bit values that reports its minimum after every request.
// Request channel: drive mode (0 push, 1 pop) and value with start; the request
// is taken at a rising edge where start is high and busy is low.
// Result channel: done is high for exactly one cycle while min_value, count,
// is_empty and status describe the queue after the request. The receiver
// cannot stall, so take the result in that cycle.
// States passed, from the accepting edge until idle again:
//   push, or any refused request        S_RESP
//   pop with the output stack non-empty S_POP_WAIT, S_RESP
//   pop that first moves N elements     S_XFER once per element, S_POP,
//                                        S_POP_WAIT, S_RESP
// The move runs one element a cycle through the input stack's read port.
// Pops wait on the output stack's registered read to restore the new top
// minimum.
// Reset (rst, synchronous) empties both stacks and returns to idle; the
// stack memories are not cleared since only entries below a count are read.
// A push on a full queue or a pop on an empty one is dropped with status set.
module min_queue_two_stacks_core
  import mqts_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 start,
  input  logic                 mode,
  input  logic signed [DW-1:0] value,
  output logic                 busy,
  output logic                 done,
  output logic signed [DW-1:0] min_value,
  output logic [CW-1:0]        count,
  output logic                 is_empty,
  output logic [1:0]           status
);

  dp_cmd_t cmd;
  dp_sts_t sts;
  status_t status_q;

  // Sequence each request: decide at acceptance, then move, pop and report.
  mqts_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .mode  (mode),
    .sts   (sts),
    .cmd   (cmd),
    .busy  (busy),
    .done  (done)
  );

  // Hold stacks, counts and top minima; build the result fields.
  mqts_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .value     (value),
    .sts       (sts),
    .min_value (min_value),
    .count     (count),
    .is_empty  (is_empty),
    .status    (status_q)
  );

  assign status = status_q;

endmodule

// ----- rtl/mqts_checker.sv -----
// Port-level checks for the minimum queue, bound to the top level.
module mqts_checker
  import mqts_pkg::*;
(
  input logic                 clk,
  input logic                 rst,
  input logic                 start,
  input logic                 busy,
  input logic                 done,
  input logic signed [DW-1:0] min_value,
  input logic [CW-1:0]        count,
  input logic                 is_empty
);

  // a result only appears while a request is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst) done |-> busy)
    else $error("result strobe while idle");

  // an accepted request makes the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("accepted request did not raise busy");

  // one strobe per request
  a_done_single: assert property (@(posedge clk) disable iff (rst) done |=> !done)
    else $error("result strobe held for two cycles");

  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    done |-> (is_empty == (count == '0)))
    else $error("empty flag disagrees with count");

  a_empty_min: assert property (@(posedge clk) disable iff (rst)
    done && is_empty |-> min_value == '0)
    else $error("empty queue reports non-zero minimum");

endmodule

bind min_queue_two_stacks_core mqts_checker u_mqts_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .done      (done),
  .min_value (min_value),
  .count     (count),
  .is_empty  (is_empty)
);
